/* sv/arx_stream_cipher_keystream_macros.svh */
// ----------------------------------------------------------------------------
// ARX keystream assertion macros
// Shared assertion forms for the checker of the keystream block.
// ----------------------------------------------------------------------------
`ifndef ARX_STREAM_CIPHER_KEYSTREAM_MACROS_SVH
`define ARX_STREAM_CIPHER_KEYSTREAM_MACROS_SVH

// A property checked at every clock edge outside of reset.
`define ARXSCK_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A property that must hold whenever a result is offered.
`define ARXSCK_ASSERT_OUT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> prop) else $error(msg);

`endif

/* sv/arxsck_pkg.sv */
// ----------------------------------------------------------------------------
// ARX keystream package
// Types, constants and helper functions shared by the keystream modules.
// ----------------------------------------------------------------------------
package arxsck_pkg;

	localparam int WORD_W    = 64;
	localparam int NUM_WORDS = 8;
	localparam int IDX_W     = 3;
	localparam int CNT_W     = 4;
	localparam int MAX_BYTES = 8;
	localparam int ROT_AMT   = 9;
	localparam int WARM_A    = 2;
	localparam int WARM_B    = 62;
	localparam int RND_W     = 6;
	localparam int NUM_CFG   = 6;
	localparam int CFG_IDX_W = 3;
	localparam int KS_STEPS  = 7;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = 1;
	localparam int QFILL_W   = 2;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0]  count_t;
	typedef logic [IDX_W-1:0]  idx_t;

	typedef enum logic {
		OP_SETUP = 1'b0,
		OP_DATA  = 1'b1
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY0   = 3'd0,
		REG_KEY1   = 3'd1,
		REG_KEY2   = 3'd2,
		REG_KEY3   = 3'd3,
		REG_NONCE0 = 3'd4,
		REG_NONCE1 = 3'd5
	} reg_idx_t;

	typedef logic [NUM_CFG-1:0][WORD_W-1:0] cfg_t;

	typedef struct packed {
		op_t    op;
		word_t  data;
		count_t count;
	} item_t;

	// Head of the queue as seen by the round engine.
	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

	// Finished data item handed to the output stage.
	typedef struct packed {
		logic   push;
		word_t  data;
		word_t  ks;
		count_t count;
	} res_t;

	function automatic word_t rotl(input word_t v);
		return (v << ROT_AMT) | (v >> (WORD_W - ROT_AMT));
	endfunction

	// Round word combined into the keystream at each step of the chain.
	function automatic idx_t ks_operand(input idx_t step);
		idx_t r;
		unique case (step)
			3'd0:    r = 3'd6;
			3'd1:    r = 3'd1;
			3'd2:    r = 3'd5;
			3'd3:    r = 3'd2;
			3'd4:    r = 3'd4;
			3'd5:    r = 3'd3;
			default: r = 3'd7;
		endcase
		return r;
	endfunction

	// Even steps of the chain add, odd steps XOR.
	function automatic logic ks_is_add(input idx_t step);
		return ~step[0];
	endfunction

	function automatic word_t byte_mask(input count_t count);
		word_t m;
		for (int b = 0; b < MAX_BYTES; b++) begin
			m[b*8 +: 8] = (count_t'(b) < count) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

/* sv/arxsck_front.sv */
// ----------------------------------------------------------------------------
// ARX keystream front end
// Holds the configuration registers, accepts items, clamps the byte count
// and queues items for the round engine.
// ----------------------------------------------------------------------------
module arxsck_front
	import arxsck_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  word_t                cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 operation,
	input  word_t                data_in,
	input  count_t               valid_bytes,
	input  logic                 pop,
	output qhead_t               head,
	output cfg_t                 cfg
);

	cfg_t                cfg_q;
	item_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QFILL_W-1:0]  fill_q;
	logic                push;
	logic                take;
	item_t               item_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY0:   cfg_q[REG_KEY0]   <= cfg_data;
				REG_KEY1:   cfg_q[REG_KEY1]   <= cfg_data;
				REG_KEY2:   cfg_q[REG_KEY2]   <= cfg_data;
				REG_KEY3:   cfg_q[REG_KEY3]   <= cfg_data;
				REG_NONCE0: cfg_q[REG_NONCE0] <= cfg_data;
				REG_NONCE1: cfg_q[REG_NONCE1] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Counts above a full word are treated as a full word.
	always_comb begin
		item_new.op    = op_t'(operation);
		item_new.data  = data_in;
		item_new.count = (valid_bytes > count_t'(MAX_BYTES)) ? count_t'(MAX_BYTES)
		                                                     : valid_bytes;
	end

	assign in_stall = (fill_q == QFILL_W'(QDEPTH));
	assign push     = in_valid & ~in_stall;
	assign take     = pop & (fill_q != '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= item_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !take) begin
				fill_q <= fill_q + 1'b1;
			end else if (take && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	assign head.valid = (fill_q != '0);
	assign head.item  = mem_q[rd_ptr_q];
	assign cfg        = cfg_q;

endmodule

/* sv/arxsck_core.sv */
// ----------------------------------------------------------------------------
// ARX keystream round engine
// Runs set-up and data items: one round word per cycle, the accumulator
// sums and the keystream chain, one operation per cycle.
// ----------------------------------------------------------------------------
module arxsck_core
	import arxsck_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  qhead_t head,
	output logic   pop,
	input  logic   room,
	output res_t   res
);

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_LOAD   = 7'b0000010,
		S_ACC    = 7'b0000100,
		S_STEP   = 7'b0001000,
		S_FINISH = 7'b0010000,
		S_KS     = 7'b0100000,
		S_DONE   = 7'b1000000
	} state_t;

	state_t           state_q;
	idx_t             idx_q;
	logic [RND_W-1:0] rnd_q;
	logic             warm_b_q;
	logic             is_data_q;
	word_t            w_q  [NUM_WORDS];
	word_t            nw_q [NUM_WORDS];
	word_t            a_q;
	word_t            ks_q;
	word_t            data_q;
	count_t           count_q;

	logic             last_idx;
	word_t            nb;
	word_t            nv;
	word_t            ks_prev;
	word_t            ks_op;

	assign last_idx = (idx_q == idx_t'(NUM_WORDS - 1));

	// The old words rotate so the current one sits at place 0; on the last
	// word the neighbor is the freshly updated first word.
	assign nb = last_idx ? nw_q[1] : w_q[1];
	assign nv = rotl((w_q[0] + nb + a_q) ^ w_q[0]);

	assign ks_prev = (idx_q == '0) ? w_q[0] : ks_q;
	assign ks_op   = w_q[ks_operand(idx_q)];

	assign pop = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			rnd_q     <= '0;
			warm_b_q  <= 1'b0;
			is_data_q <= 1'b0;
			a_q       <= '0;
			for (int k = 0; k < NUM_WORDS; k++) begin
				w_q[k] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (head.valid) begin
						is_data_q <= (head.item.op == OP_DATA);
						if (head.item.op == OP_DATA) begin
							rnd_q   <= '0;
							state_q <= S_STEP;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					w_q[0]   <= cfg[REG_KEY0] ^ cfg[REG_NONCE0];
					w_q[1]   <= cfg[REG_KEY1] ^ cfg[REG_NONCE1];
					w_q[2]   <= cfg[REG_KEY2];
					w_q[3]   <= cfg[REG_KEY3];
					for (int k = 4; k < NUM_WORDS; k++) begin
						w_q[k] <= '0;
					end
					a_q      <= '0;
					warm_b_q <= 1'b0;
					idx_q    <= '0;
					state_q  <= S_ACC;
				end
				S_ACC: begin
					a_q <= a_q + w_q[0];
					for (int k = 0; k < NUM_WORDS; k++) begin
						w_q[k] <= w_q[(k + 1) % NUM_WORDS];
					end
					idx_q <= idx_q + 1'b1;
					if (last_idx) begin
						rnd_q   <= warm_b_q ? RND_W'(WARM_B - 1) : RND_W'(WARM_A - 1);
						state_q <= S_STEP;
					end
				end
				S_STEP: begin
					a_q <= a_q + nv;
					for (int k = 0; k < NUM_WORDS; k++) begin
						w_q[k] <= w_q[(k + 1) % NUM_WORDS];
					end
					idx_q <= idx_q + 1'b1;
					if (last_idx) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					for (int k = 0; k < NUM_WORDS; k++) begin
						w_q[k] <= w_q[k] + nw_q[k];
					end
					idx_q <= '0;
					priority if (is_data_q) begin
						state_q <= S_KS;
					end else if (rnd_q != '0) begin
						rnd_q   <= rnd_q - 1'b1;
						state_q <= S_STEP;
					end else if (!warm_b_q) begin
						warm_b_q <= 1'b1;
						state_q  <= S_ACC;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_KS: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == idx_t'(KS_STEPS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (room) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && head.valid) begin
			data_q  <= head.item.data;
			count_q <= head.item.count;
		end
		if (state_q == S_STEP) begin
			for (int k = 0; k < NUM_WORDS - 1; k++) begin
				nw_q[k] <= nw_q[k + 1];
			end
			nw_q[NUM_WORDS - 1] <= nv;
		end
		if (state_q == S_KS) begin
			ks_q <= ks_is_add(idx_q) ? (ks_prev + ks_op) : (ks_prev ^ ks_op);
		end
	end

	assign res.push  = (state_q == S_DONE) & room;
	assign res.data  = data_q;
	assign res.ks    = ks_q;
	assign res.count = count_q;

endmodule

/* sv/arxsck_out.sv */
// ----------------------------------------------------------------------------
// ARX keystream output stage
// Applies the keystream and byte mask and holds the result until taken.
// ----------------------------------------------------------------------------
module arxsck_out
	import arxsck_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  res_t   res,
	output logic   room,
	output logic   out_valid,
	input  logic   out_stall,
	output word_t  data_out,
	output count_t valid_bytes_out
);

	logic   valid_q;
	word_t  data_q;
	count_t count_q;

	assign room = ~valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res.push) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.push) begin
			data_q  <= (res.data ^ res.ks) & byte_mask(res.count);
			count_q <= res.count;
		end
	end

	assign out_valid       = valid_q;
	assign data_out        = data_q;
	assign valid_bytes_out = count_q;

endmodule

/* sv/arx_stream_cipher_keystream.sv */
// ----------------------------------------------------------------------------
// ARX stream cipher keystream block
// Add-xor-rotate keystream generator: set-up from key and nonce, then one
// fresh keystream word XORed onto each data item.
// ----------------------------------------------------------------------------
// Channel   Handshake             Payload
// config    cfg_we                cfg_index, cfg_data
// input     in_valid / in_stall   operation, data_in, valid_bytes
// output    out_valid / out_stall data_out, valid_bytes_out
//
// A data item runs in the round engine as a start, the eight round words (one
// word per cycle through a single adder chain), a fold of the old words, the
// keystream chain and a hand-off that waits for room at the output. A set-up
// item runs a start, a load of the words, two accumulator passes over the
// eight words and 64 rounds.
// Reset clears the state to zero; no clearing pass.
// A two-entry queue takes items while the engine works, and the output
// register lets the engine finish the next item while a result is stalled.
// ----------------------------------------------------------------------------
module arx_stream_cipher_keystream
	import arxsck_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  word_t                cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 operation,
	input  word_t                data_in,
	input  count_t               valid_bytes,
	output logic                 out_valid,
	input  logic                 out_stall,
	output word_t                data_out,
	output count_t               valid_bytes_out
);

	qhead_t head;
	cfg_t   cfg;
	logic   pop;
	logic   room;
	res_t   res;

	arxsck_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.data_in     (data_in),
		.valid_bytes (valid_bytes),
		.pop         (pop),
		.head        (head),
		.cfg         (cfg)
	);

	arxsck_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.head   (head),
		.pop    (pop),
		.room   (room),
		.res    (res)
	);

	arxsck_out u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.res             (res),
		.room            (room),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.data_out        (data_out),
		.valid_bytes_out (valid_bytes_out)
	);

endmodule

/* sv/arxsck_checker.sv */
// ----------------------------------------------------------------------------
// ARX keystream checker
// Port-level assertions on the result channel of the keystream block.
// ----------------------------------------------------------------------------
`include "arx_stream_cipher_keystream_macros.svh"

module arxsck_checker
	import arxsck_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   out_valid,
	input logic   out_stall,
	input word_t  data_out,
	input count_t valid_bytes_out
);

	logic [WORD_W+CNT_W-1:0] out_word;

	assign out_word = {data_out, valid_bytes_out};

	`ARXSCK_ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "stalled result dropped")
	`ARXSCK_ASSERT_CLK(a_out_stable, out_valid && out_stall |=> $stable(out_word), "result changed")
	`ARXSCK_ASSERT_OUT(a_count_range, valid_bytes_out <= count_t'(MAX_BYTES), "count too large")
	`ARXSCK_ASSERT_OUT(a_tail_zero, (data_out & ~byte_mask(valid_bytes_out)) == '0, "tail not zero")

endmodule

bind arx_stream_cipher_keystream arxsck_checker u_arxsck_checker (.*);

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// ARX keystream block testbench
// Drives set-up and data items through the keystream block and checks every
// enciphered word against an in-bench model of the cipher state. It covers a
// directed table, then random message traffic under several key and nonce
// settings, with sender gaps, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import arxsck_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Register indexes past the end of the list; writes to them are dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

	localparam int NUM_PHASES  = 8;
	localparam int PHASE_ITEMS = 68;
	localparam int HOLD_CYCLES = 400;
	// Long enough for three set-up items (queue plus engine) to finish.
	localparam int SETTLE_CYCLES = 2000;
	// Worst case is every item a set-up with full stalls; this is several times that.
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		word_t  data;
		count_t count;
	} cipher_result_t;

	typedef struct packed {
		op_t            op;
		word_t          data;
		count_t         count;
		cipher_result_t want;
	} stim_row_t;

	// The state is all zero here (reset, then set-up with zero key), so the
	// keystream is zero and each result is the masked data.
	stim_row_t directed_rows [0:12] = '{
		'{OP_DATA,  64'hFFFFFFFFFFFFFFFF, 4'd8,  '{64'hFFFFFFFFFFFFFFFF, 4'd8}},
		'{OP_DATA,  64'h0000000000000000, 4'd8,  '{64'h0000000000000000, 4'd8}},
		'{OP_DATA,  64'h0123456789ABCDEF, 4'd3,  '{64'h0000000000ABCDEF, 4'd3}},
		'{OP_DATA,  64'h8000000000000001, 4'd1,  '{64'h0000000000000001, 4'd1}},
		'{OP_DATA,  64'hFFFFFFFFFFFFFFFF, 4'd0,  '{64'h0000000000000000, 4'd0}},
		'{OP_DATA,  64'hFFFFFFFFFFFFFFFF, 4'd9,  '{64'hFFFFFFFFFFFFFFFF, 4'd8}},
		'{OP_DATA,  64'hFFFFFFFFFFFFFFFF, 4'd15, '{64'hFFFFFFFFFFFFFFFF, 4'd8}},
		'{OP_DATA,  64'hFEDCBA9876543210, 4'd7,  '{64'h00DCBA9876543210, 4'd7}},
		'{OP_SETUP, 64'h0000000000000000, 4'd8,  '{64'h0000000000000000, 4'd0}},
		'{OP_DATA,  64'hA5A5A5A5A5A5A5A5, 4'd8,  '{64'hA5A5A5A5A5A5A5A5, 4'd8}},
		'{OP_DATA,  64'h5A5A5A5A5A5A5A5A, 4'd4,  '{64'h000000005A5A5A5A, 4'd4}},
		'{OP_SETUP, 64'hFFFFFFFFFFFFFFFF, 4'd0,  '{64'h0000000000000000, 4'd0}},
		'{OP_DATA,  64'h0123456789ABCDEF, 4'd2,  '{64'h000000000000CDEF, 4'd2}}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	word_t                cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 operation = OP_SETUP;
	word_t                data_in = '0;
	count_t               valid_bytes = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	word_t                data_out;
	count_t               valid_bytes_out;

	// Model of the cipher state and registers.
	word_t round_word [NUM_WORDS];
	word_t mix_acc;
	word_t key_regs [NUM_CFG];
	word_t cfg_vals [NUM_CFG];

	cipher_result_t pending_cipher [$];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int hold_left = 0;
	int error_count = 0;
	int items_sent = 0;
	int setups_sent = 0;
	int results_seen = 0;
	int cycle_count = 0;

	arx_stream_cipher_keystream uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.data_in         (data_in),
		.valid_bytes     (valid_bytes),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.data_out        (data_out),
		.valid_bytes_out (valid_bytes_out)
	);

	always #2 clk = ~clk;

	function automatic word_t rot_left9(input word_t v);
		return {v[WORD_W-10:0], v[WORD_W-1:WORD_W-9]};
	endfunction

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic word_t data_word();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return rand_word();
	endfunction

	task automatic mix_round();
		word_t saved [NUM_WORDS];
		word_t t;
		for (int i = 0; i < NUM_WORDS; i++)
			saved[i] = round_word[i];
		// Word 7 sees the already-updated word 0 as its neighbor.
		for (int i = 0; i < NUM_WORDS; i++) begin
			t = round_word[i] + round_word[(i + 1) % NUM_WORDS] + mix_acc;
			round_word[i] = rot_left9(t ^ round_word[i]);
			mix_acc += round_word[i];
		end
		for (int i = 0; i < NUM_WORDS; i++)
			round_word[i] += saved[i];
	endtask

	task automatic fold_words();
		for (int i = 0; i < NUM_WORDS; i++)
			mix_acc += round_word[i];
	endtask

	task automatic load_cipher_state();
		for (int i = 0; i < NUM_WORDS; i++)
			round_word[i] = (i < 4) ? key_regs[i] : '0;
		round_word[0] ^= key_regs[REG_NONCE0];
		round_word[1] ^= key_regs[REG_NONCE1];
		mix_acc = '0;
		fold_words();
		repeat (WARM_A) mix_round();
		fold_words();
		repeat (WARM_B) mix_round();
	endtask

	task automatic predict_cipher(input op_t op, input word_t d, input count_t c,
			output logic has_result, output cipher_result_t res);
		word_t ks;
		word_t mask;
		count_t eff;
		has_result = 1'b0;
		res = '0;
		if (op == OP_SETUP) begin
			load_cipher_state();
		end else begin
			eff = (c > MAX_BYTES) ? count_t'(MAX_BYTES) : c;
			mix_round();
			ks = ((((((round_word[0] + round_word[6]) ^ round_word[1]) + round_word[5])
				^ round_word[2]) + round_word[4]) ^ round_word[3]) + round_word[7];
			mask = (eff == MAX_BYTES) ? '1 : ((word_t'(1) << (eff * 8)) - word_t'(1));
			has_result = 1'b1;
			res.data = (d ^ ks) & mask;
			res.count = eff;
		end
	endtask

	task automatic report_mismatch(input string what, input word_t got, input word_t want);
		error_count++;
		if (error_count <= 50)
			$display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
	endtask

	// Offers one item and returns at the edge where it is accepted; valid stays
	// high so a back-to-back item needs no second assignment in this step.
	task automatic drive_item(input op_t op, input word_t d, input count_t c,
			input logic typed, input cipher_result_t typed_want);
		logic has_result;
		cipher_result_t res;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		data_in <= d;
		valid_bytes <= c;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_cipher(op, d, c, has_result, res);
		if (has_result)
			pending_cipher.push_back(typed ? typed_want : res);
		items_sent++;
		if (op == OP_SETUP)
			setups_sent++;
	endtask

	task automatic send_message(input int words);
		for (int w = 0; w < words; w++)
			drive_item(OP_DATA, data_word(),
				(w == words - 1) ? count_t'($urandom_range(1, MAX_BYTES)) : count_t'(MAX_BYTES),
				1'b0, '0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_cipher.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input word_t v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		if (idx < NUM_CFG)
			key_regs[idx] = v;
		@(posedge clk);
	endtask

	task automatic load_registers();
		write_reg(REG_KEY0, cfg_vals[REG_KEY0]);
		write_reg(REG_KEY1, cfg_vals[REG_KEY1]);
		write_reg(REG_KEY2, cfg_vals[REG_KEY2]);
		write_reg(REG_KEY3, cfg_vals[REG_KEY3]);
		write_reg(REG_NONCE0, cfg_vals[REG_NONCE0]);
		write_reg(REG_NONCE1, cfg_vals[REG_NONCE1]);
		write_reg(REG_SPARE6, rand_word());
		write_reg(REG_SPARE7, rand_word());
		cfg_we <= 1'b0;
	endtask

	// Receiver: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		cipher_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_cipher.size() == 0) begin
				report_mismatch("unexpected item, data_out", data_out, '0);
			end else begin
				want = pending_cipher.pop_front();
				if (data_out !== want.data)
					report_mismatch("data_out", data_out, want.data);
				if (valid_bytes_out !== want.count)
					report_mismatch("valid_bytes_out", word_t'(valid_bytes_out),
						word_t'(want.count));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, pending_cipher.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int sent_before;
		int r;
		for (int i = 0; i < NUM_WORDS; i++)
			round_word[i] = '0;
		mix_acc = '0;
		for (int i = 0; i < NUM_CFG; i++)
			key_regs[i] = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			drive_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].count,
				1'b1, directed_rows[i].want);

		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			// Set-up items leave nothing to wait for, so let the engine run dry.
			repeat (SETTLE_CYCLES) @(posedge clk);
			for (int i = 0; i < NUM_CFG; i++) begin
				case (p)
					0: cfg_vals[i] = '1;
					1: cfg_vals[i] = '0;
					2: cfg_vals[i] = (i < 4) ? '1 : '0;
					3: cfg_vals[i] = (i < 4) ? '0 : '1;
					default: cfg_vals[i] = rand_word();
				endcase
			end
			load_registers();
			case (p % 4)
				0: begin send_idle_pct = 0; stall_pct = 0; end
				1: begin send_idle_pct = 54; stall_pct = 0; end
				2: begin send_idle_pct = 0; stall_pct = 54; end
				default: begin send_idle_pct = 10; stall_pct = 10; end
			endcase

			// New registers must not touch the running state until the next set-up.
			sent_before = items_sent;
			repeat ($urandom_range(0, 2))
				drive_item(OP_DATA, data_word(), count_t'(MAX_BYTES), 1'b0, '0);
			drive_item(OP_SETUP, rand_word(), count_t'($urandom_range(0, 15)), 1'b0, '0);

			while (items_sent - sent_before < PHASE_ITEMS) begin
				if (p == 4 && hold_requests == 0 && items_sent - sent_before >= 20)
					hold_requests++;
				if (p == 5 && items_sent - sent_before >= 30 &&
						items_sent - sent_before < 34)
					wait_drained();
				r = $urandom_range(0, 99);
				if (r < 6)
					drive_item(OP_SETUP, rand_word(), count_t'($urandom_range(0, 15)),
						1'b0, '0);
				else if (r < 16)
					drive_item(OP_DATA, data_word(), count_t'($urandom_range(0, 15)),
						1'b0, '0);
				else
					send_message($urandom_range(1, 6));
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d items (%0d set-up) over %0d key and nonce settings;",
			items_sent, setups_sent, NUM_PHASES + 1);
		$display("checked %0d enciphered words with gaps, stalls and a long hold-off.",
			results_seen);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* files.f */
+incdir+sv
sv/arxsck_pkg.sv
sv/arxsck_front.sv
sv/arxsck_core.sv
sv/arxsck_out.sv
sv/arx_stream_cipher_keystream.sv
sv/arxsck_checker.sv
tb/sv/tb_top.sv
